// ----- design/gms_pkg.sv -----
// Shared types, constants and constant tables of the Gaussian mixture scorer.
package gms_pkg;

	localparam int NUM_COMPS  = 8;
	localparam int NUM_DIMS   = 4;
	localparam int COMP_W     = $clog2(NUM_COMPS);
	localparam int DIM_W      = $clog2(NUM_DIMS);
	localparam int ADDR_W     = COMP_W + DIM_W;
	localparam int TBL_DEPTH  = NUM_COMPS * NUM_DIMS;
	localparam int DATA_W     = 32;
	localparam int DIMS_W     = 3;
	localparam int COMPS_W    = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;
	localparam int VAR_W      = 31;
	localparam int PRIOR_W    = 17;
	localparam int LN_W       = 24;
	localparam int PROD_W     = 64;
	localparam int Q_W        = 41;
	localparam int HALF_W     = 42;
	localparam int LK_W       = 34;
	localparam int EXPD_W     = 35;
	localparam int EXPR_W     = 17;
	localparam int TOT_W      = 20;
	localparam int FRAC_W     = 16;

	localparam logic [DIMS_W-1:0]  DIMS_RST   = 3'd4;
	localparam logic [COMPS_W-1:0] COMPS_RST  = 4'd8;
	localparam logic [VAR_W-1:0]   VAR_RST    = 31'd65536;
	localparam logic [PRIOR_W-1:0] ONE_Q16    = 17'd65536;
	localparam logic [PRIOR_W-1:0] PRIOR_RST  = 17'(65536 / NUM_COMPS);
	localparam logic [31:0]        LN2_Q32    = 32'd2977044472;
	localparam logic [30:0]        LOG2E_Q30  = 31'd1549082005;
	localparam logic signed [42:0] LN2PI_Q16  = 43'sd120447;
	localparam logic signed [EXPD_W-1:0] EXP_DMIN = -35'sd1572864;
	localparam logic [Q_W-1:0]     Q_CAP      = 41'd1 << 40;
	localparam logic signed [LK_W-1:0] LK_I32MIN = -34'sd2147483648;
	localparam logic signed [47:0] I32_MIN48  = -48'sd2147483648;
	localparam logic signed [47:0] I32_MAX48  = 48'sd2147483647;

	typedef enum logic [1:0] {
		FUNC_MEAN   = 2'd0,
		FUNC_VAR    = 2'd1,
		FUNC_PRIOR  = 2'd2,
		FUNC_SAMPLE = 2'd3
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DIMS  = 2'd0,
		CFG_COMPS = 2'd1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		LN_VAR,
		LN_PRIOR,
		LN_TOTAL
	} ln_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIVI,
		ST_WAIT,
		ST_SUM1,
		ST_SUM2,
		ST_FLN,
		ST_FLNW,
		ST_FCHK,
		ST_FEXP,
		ST_FEXW,
		ST_FLNT,
		ST_FLNTW,
		ST_EMIT
	} state_t;

	typedef struct packed {
		func_t              func;
		logic [2:0]         component_index;
		logic [1:0]         dim_index;
		logic signed [31:0] data_value;
	} item_t;

	typedef struct packed {
		logic signed [31:0] log_density;
		logic               saturated;
	} result_t;

	typedef struct packed {
		logic              load;
		logic              take;
		logic [COMP_W-1:0] k;
		logic [DIM_W-1:0]  d;
		logic              first;
		logic              mul;
		logic              div_init;
		logic              sum1;
		logic              sum2;
		logic              fin_init;
		logic              ln_start;
		ln_sel_t           ln_sel;
		logic              lk_store;
		logic              exp_start;
		logic              tot_add;
		logic              emit;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic ln_busy;
		logic exp_busy;
		logic prior_pos;
		logic lk_valid;
		logic none;
		logic out_free;
	} sts_t;

	typedef logic [FRAC_W-1:0][30:0] root_tbl_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] rem;
		logic [63:0] r;
		logic [63:0] b;
		rem = v;
		r = '0;
		b = 64'd1 << 62;
		for (int j = 0; j < 32; j++) begin
			if (rem >= r + b) begin
				rem = rem - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Repeated square roots of 2.0 in Q30, entry i is 2^(2^(i-16))
	function automatic root_tbl_t make_roots();
		root_tbl_t   t;
		logic [63:0] root;
		root = 64'd2 << 30;
		for (int i = FRAC_W - 1; i >= 0; i--) begin
			root = isqrt64(root << 30);
			t[i] = root[30:0];
		end
		return t;
	endfunction

	localparam root_tbl_t EXP_ROOTS = make_roots();

	function automatic logic signed [31:0] sat_i32(input logic signed [47:0] v);
		logic signed [31:0] r;
		if (v < I32_MIN48) r = 32'sh8000_0000;
		else if (v > I32_MAX48) r = 32'sh7FFF_FFFF;
		else r = 32'(v);
		return r;
	endfunction

endpackage

// ----- design/gms_ln.sv -----
// Iterative natural-log unit: ln(v / 65536) in Q16.16.
module gms_ln import gms_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [DATA_W-1:0]       v,
	output logic                    busy,
	output logic signed [LN_W-1:0]  res
);

	localparam logic [4:0] NORM_END = 5'd5;
	localparam logic [4:0] SQ_END   = 5'd21;
	localparam logic [4:0] MUL_STEP = 5'd21;

	logic               busy_q;
	logic [4:0]         step_q;
	logic [31:0]        m_q;
	logic [4:0]         sh_q;
	logic [FRAC_W-1:0]  frac_q;
	logic               neg_q;
	logic [52:0]        mp_q;
	logic signed [LN_W-1:0] res_q;

	logic [4:0]         norm_w;
	logic [31:0]        norm_mask;
	logic               top_zero;
	logic [63:0]        sq;
	logic [32:0]        t;
	logic signed [20:0] l2;
	logic [20:0]        mag;
	logic [52:0]        rnd;
	logic [20:0]        r;

	always_comb begin
		case (step_q)
			5'd0:    norm_w = 5'd16;
			5'd1:    norm_w = 5'd8;
			5'd2:    norm_w = 5'd4;
			5'd3:    norm_w = 5'd2;
			default: norm_w = 5'd1;
		endcase
		norm_mask = ~(32'hFFFF_FFFF >> norm_w);
		top_zero  = (m_q & norm_mask) == '0;
		sq  = m_q * m_q;
		t   = sq[63:31];
		l2  = $signed({5'(5'd15 - sh_q), frac_q});
		mag = l2[20] ? 21'(-l2) : 21'(l2);
		rnd = mp_q + (53'd1 << 31);
		r   = rnd[52:32];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 5'd1;
			if (step_q > MUL_STEP) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			m_q    <= v;
			sh_q   <= '0;
			frac_q <= '0;
		end else if (busy_q) begin
			if (step_q < NORM_END) begin
				// binary search for the leading one
				if (top_zero) begin
					m_q  <= m_q << norm_w;
					sh_q <= sh_q + norm_w;
				end
			end else if (step_q < SQ_END) begin
				m_q    <= t[32] ? t[32:1] : t[31:0];
				frac_q <= {frac_q[FRAC_W-2:0], t[32]};
			end else if (step_q == MUL_STEP) begin
				neg_q <= l2[20];
				mp_q  <= mag * LN2_Q32;
			end else begin
				res_q <= neg_q ? -$signed({3'b0, r}) : $signed({3'b0, r});
			end
		end
	end

	assign busy = busy_q;
	assign res  = res_q;

endmodule

// ----- design/gms_exp.sv -----
// Iterative exp unit for non-positive arguments, Q16.16 in and out.
module gms_exp import gms_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [EXPD_W-1:0] d,
	output logic                     busy,
	output logic [EXPR_W-1:0]        res
);

	localparam logic [5:0] POW_BEG  = 6'd2;
	localparam logic [5:0] POW_LAST = 6'd17;
	localparam logic [5:0] DIV_LAST = 6'd34;

	logic                busy_q;
	logic [5:0]          step_q;
	logic [20:0]         mag_q;
	logic [51:0]         prod_q;
	logic [4:0]          n_q;
	logic [FRAC_W-1:0]   f_q;
	logic [30:0]         pw_q;
	logic [30:0]         rem_q;
	logic [EXPR_W-1:0]   q_q;
	logic [EXPR_W-1:0]   res_q;

	logic                too_small;
	logic [21:0]         u;
	logic                u_big;
	logic [3:0]          idx;
	logic [61:0]         pp;
	logic [31:0]         rem2;
	logic                ge;
	logic [EXPR_W-1:0]   q_new;

	always_comb begin
		too_small = d < EXP_DMIN;
		u     = prod_q[51:30];
		u_big = u[21:16] >= 6'd17;
		idx   = 4'(POW_LAST - step_q);
		pp    = pw_q * EXP_ROOTS[idx];
		rem2  = {rem_q, 1'b0};
		ge    = rem2 >= {1'b0, pw_q};
		q_new = {q_q[EXPR_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= !too_small;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 6'd1;
			if ((step_q == 6'd1 && u_big) || step_q == DIV_LAST) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= d[EXPD_W-1] ? 21'(-d) : '0;
			if (too_small) res_q <= '0;
		end else if (busy_q) begin
			if (step_q == 6'd0) begin
				prod_q <= mag_q * LOG2E_Q30;
			end else if (step_q == 6'd1) begin
				n_q   <= u[20:16];
				f_q   <= u[15:0];
				pw_q  <= 31'd1 << 30;
				rem_q <= 31'd1 << 29;
				q_q   <= '0;
				if (u_big) res_q <= '0;
			end else if (step_q >= POW_BEG && step_q <= POW_LAST) begin
				if (f_q[idx]) pw_q <= pp[60:30];
			end else begin
				// 2^46 / pw, one quotient bit per step
				rem_q <= ge ? 31'(rem2 - {1'b0, pw_q}) : rem2[30:0];
				q_q   <= q_new;
				if (step_q == DIV_LAST) res_q <= q_new >> n_q;
			end
		end
	end

	assign busy = busy_q;
	assign res  = res_q;

endmodule

// ----- design/gms_dp.sv -----
// Datapath: model tables, squared-distance divider, sums and output register.
module gms_dp import gms_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  item_t   item,
	input  cmd_t    cmd,
	output sts_t    sts,
	output result_t result,
	output logic    result_valid,
	input  logic    result_ready
);

	logic signed [31:0]       mean_q  [TBL_DEPTH];
	logic [VAR_W-1:0]         var_q   [TBL_DEPTH];
	logic [PRIOR_W-1:0]       prior_q [NUM_COMPS];
	logic signed [31:0]       sum_q   [NUM_COMPS];
	logic signed [LK_W-1:0]   lk_q    [NUM_COMPS];
	logic [NUM_COMPS-1:0]     lkv_q;
	logic                     any_q;
	logic signed [LK_W-1:0]   best_q;
	logic [TOT_W-1:0]         total_q;

	logic signed [31:0]       val_q;
	logic [PROD_W-1:0]        prod_q;
	logic [VAR_W-1:0]         var_hold_q;
	logic                     div_busy_q;
	logic [5:0]               dcnt_q;
	logic [30:0]              rem_q;
	logic [Q_W-1:0]           dlo_q;
	logic [Q_W-1:0]           q_q;
	logic signed [HALF_W-1:0] half_q;
	result_t                  out_q;
	logic                     out_valid_q;

	logic [ADDR_W-1:0]        ld_addr;
	logic [ADDR_W-1:0]        rd_addr;
	logic signed [32:0]       diff;
	logic [31:0]              ad;
	logic [VAR_W-1:0]         var_rd;
	logic [22:0]              hi;
	logic [31:0]              rem2;
	logic                     ge;
	logic [Q_W-1:0]           qc;
	logic signed [42:0]       p;
	logic signed [42:0]       p_adj;
	logic signed [31:0]       acc;
	logic signed [LK_W-1:0]   lk;
	logic                     ln_busy;
	logic signed [LN_W-1:0]   ln_res;
	logic [DATA_W-1:0]        ln_v;
	logic                     exp_busy;
	logic [EXPR_W-1:0]        exp_res;
	logic signed [EXPD_W-1:0] exp_d;
	logic                     none;

	always_comb begin
		ld_addr = {item.component_index, item.dim_index};
		rd_addr = {cmd.k, cmd.d};
		diff    = 33'(val_q) - 33'(mean_q[rd_addr]);
		ad      = diff[32] ? 32'(-diff) : diff[31:0];
		var_rd  = var_q[rd_addr];
		hi      = prod_q[63:41];
		rem2    = {rem_q, dlo_q[Q_W-1]};
		ge      = rem2 >= {1'b0, var_hold_q};
		qc      = (q_q > Q_CAP) ? Q_CAP : q_q;
		p       = $signed({2'b0, qc}) + 43'(ln_res) + LN2PI_Q16;
		// halving truncates toward zero
		p_adj   = p[42] ? p + 43'sd1 : p;
		acc     = cmd.first ? 32'sd0 : sum_q[cmd.k];
		lk      = 34'(ln_res) + 34'(sum_q[cmd.k]);
		exp_d   = 35'(lk_q[cmd.k]) - 35'(best_q);
		none    = !any_q || best_q <= LK_I32MIN;
		case (cmd.ln_sel)
			LN_VAR:   ln_v = {1'b0, var_rd};
			LN_PRIOR: ln_v = 32'(prior_q[cmd.k]);
			LN_TOTAL: ln_v = (total_q == '0) ? 32'd1 : 32'(total_q);
			default:  ln_v = 32'd1;
		endcase
	end

	// model tables and per-component sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TBL_DEPTH; i++) begin
				mean_q[i] <= '0;
				var_q[i]  <= VAR_RST;
			end
			for (int i = 0; i < NUM_COMPS; i++) begin
				prior_q[i] <= PRIOR_RST;
				sum_q[i]   <= '0;
			end
		end else begin
			if (cmd.load) begin
				case (item.func)
					FUNC_MEAN: mean_q[ld_addr] <= item.data_value;
					FUNC_VAR:  var_q[ld_addr] <= (item.data_value < 32'sd1) ?
						VAR_W'(1) : item.data_value[VAR_W-1:0];
					FUNC_PRIOR: begin
						if (item.data_value < 32'sd0)
							prior_q[item.component_index] <= '0;
						else if (item.data_value > $signed({15'b0, ONE_Q16}))
							prior_q[item.component_index] <= ONE_Q16;
						else
							prior_q[item.component_index] <= item.data_value[PRIOR_W-1:0];
					end
					default: ;
				endcase
			end
			if (cmd.sum2)
				sum_q[cmd.k] <= sat_i32(48'(acc) - 48'(half_q));
		end
	end

	// divider and finishing control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q  <= 1'b0;
			dcnt_q      <= '0;
			lkv_q       <= '0;
			any_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.div_init) begin
				div_busy_q <= {8'b0, hi} < var_hold_q;
				dcnt_q     <= '0;
			end else if (div_busy_q) begin
				dcnt_q <= dcnt_q + 6'd1;
				if (dcnt_q == 6'(Q_W - 1)) div_busy_q <= 1'b0;
			end
			if (cmd.fin_init) begin
				lkv_q <= '0;
				any_q <= 1'b0;
			end else if (cmd.lk_store) begin
				lkv_q[cmd.k] <= 1'b1;
				any_q        <= 1'b1;
			end
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (result_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) val_q <= item.data_value;
		if (cmd.mul) begin
			prod_q     <= ad * ad;
			var_hold_q <= var_rd;
		end
		if (cmd.div_init) begin
			if ({8'b0, hi} >= var_hold_q) begin
				q_q <= Q_CAP;
			end else begin
				rem_q <= {8'b0, hi};
				dlo_q <= prod_q[Q_W-1:0];
				q_q   <= '0;
			end
		end else if (div_busy_q) begin
			rem_q <= ge ? 31'(rem2 - {1'b0, var_hold_q}) : rem2[30:0];
			dlo_q <= dlo_q << 1;
			q_q   <= {q_q[Q_W-2:0], ge};
		end
		if (cmd.sum1) half_q <= HALF_W'(p_adj >>> 1);
		if (cmd.fin_init) begin
			best_q  <= '0;
			total_q <= '0;
		end else begin
			if (cmd.lk_store) begin
				lk_q[cmd.k] <= lk;
				if (!any_q || lk > best_q) best_q <= lk;
			end
			if (cmd.tot_add) total_q <= total_q + TOT_W'(exp_res);
		end
		if (cmd.emit) begin
			if (none) begin
				out_q.log_density <= 32'sh8000_0000;
				out_q.saturated   <= 1'b1;
			end else begin
				out_q.log_density <= sat_i32(48'(best_q) + 48'(ln_res));
				out_q.saturated   <= 1'b0;
			end
		end
	end

	gms_ln u_ln (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.ln_start),
		.v      (ln_v),
		.busy   (ln_busy),
		.res    (ln_res)
	);

	gms_exp u_exp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.exp_start),
		.d      (exp_d),
		.busy   (exp_busy),
		.res    (exp_res)
	);

	always_comb begin
		sts.div_busy  = div_busy_q;
		sts.ln_busy   = ln_busy;
		sts.exp_busy  = exp_busy;
		sts.prior_pos = prior_q[cmd.k] != '0;
		sts.lk_valid  = lkv_q[cmd.k];
		sts.none      = none;
		sts.out_free  = !out_valid_q || result_ready;
	end

	assign result       = out_q;
	assign result_valid = out_valid_q;

endmodule

// ----- design/gms_ctrl.sv -----
// Controller: sequencing state machine, loop counters and configuration registers.
module gms_ctrl import gms_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  func_t                 item_func,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  sts_t                  sts,
	output cmd_t                  cmd
);

	state_t             state_q, state_d;
	logic [COMP_W-1:0]  k_q;
	logic [DIM_W-1:0]   elem_q;
	logic [DIMS_W-1:0]  dims_q;
	logic [COMPS_W-1:0] comps_q;

	logic [DIMS_W-1:0]  dims_eff;
	logic [COMPS_W-1:0] comps_eff;
	logic               k_last;
	logic               elem_last;
	logic               accept;
	logic               k_inc, k_clr, elem_inc, elem_clr;

	always_comb begin
		if (dims_q == '0) dims_eff = DIMS_W'(1);
		else if (dims_q > DIMS_W'(NUM_DIMS)) dims_eff = DIMS_W'(NUM_DIMS);
		else dims_eff = dims_q;
		if (comps_q == '0) comps_eff = COMPS_W'(1);
		else if (comps_q > COMPS_W'(NUM_COMPS)) comps_eff = COMPS_W'(NUM_COMPS);
		else comps_eff = comps_q;
		k_last    = (COMPS_W'(k_q) + COMPS_W'(1)) >= comps_eff;
		elem_last = (DIMS_W'(elem_q) + DIMS_W'(1)) >= dims_eff;
		accept    = item_valid && (state_q == ST_IDLE);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (accept && item_func == FUNC_SAMPLE) state_d = ST_MUL;
			ST_MUL:   state_d = ST_DIVI;
			ST_DIVI:  state_d = ST_WAIT;
			ST_WAIT:  if (!sts.div_busy && !sts.ln_busy) state_d = ST_SUM1;
			ST_SUM1:  state_d = ST_SUM2;
			ST_SUM2: begin
				if (!k_last) state_d = ST_MUL;
				else if (!elem_last) state_d = ST_IDLE;
				else state_d = ST_FLN;
			end
			ST_FLN: begin
				if (sts.prior_pos) state_d = ST_FLNW;
				else if (k_last) state_d = ST_FCHK;
			end
			ST_FLNW:  if (!sts.ln_busy) state_d = k_last ? ST_FCHK : ST_FLN;
			ST_FCHK:  state_d = sts.none ? ST_EMIT : ST_FEXP;
			ST_FEXP: begin
				if (sts.lk_valid) state_d = ST_FEXW;
				else if (k_last) state_d = ST_FLNT;
			end
			ST_FEXW:  if (!sts.exp_busy) state_d = k_last ? ST_FLNT : ST_FEXP;
			ST_FLNT:  state_d = ST_FLNTW;
			ST_FLNTW: if (!sts.ln_busy) state_d = ST_EMIT;
			ST_EMIT:  if (sts.out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd          = '0;
		cmd.ln_sel   = LN_VAR;
		cmd.k        = k_q;
		cmd.d        = elem_q;
		cmd.first    = elem_q == '0;
		item_ready   = 1'b0;
		k_inc        = 1'b0;
		k_clr        = 1'b0;
		elem_inc     = 1'b0;
		elem_clr     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				cmd.load   = accept && item_func != FUNC_SAMPLE;
				cmd.take   = accept && item_func == FUNC_SAMPLE;
				k_clr      = 1'b1;
			end
			ST_MUL: begin
				cmd.mul      = 1'b1;
				cmd.ln_start = 1'b1;
				cmd.ln_sel   = LN_VAR;
			end
			ST_DIVI:  cmd.div_init = 1'b1;
			ST_SUM1:  cmd.sum1 = 1'b1;
			ST_SUM2: begin
				cmd.sum2 = 1'b1;
				if (!k_last) begin
					k_inc = 1'b1;
				end else begin
					k_clr = 1'b1;
					if (elem_last) begin
						elem_clr     = 1'b1;
						cmd.fin_init = 1'b1;
					end else begin
						elem_inc = 1'b1;
					end
				end
			end
			ST_FLN: begin
				if (sts.prior_pos) begin
					cmd.ln_start = 1'b1;
					cmd.ln_sel   = LN_PRIOR;
				end else begin
					k_inc = !k_last;
					k_clr = k_last;
				end
			end
			ST_FLNW: begin
				if (!sts.ln_busy) begin
					cmd.lk_store = 1'b1;
					k_inc = !k_last;
					k_clr = k_last;
				end
			end
			ST_FEXP: begin
				if (sts.lk_valid) begin
					cmd.exp_start = 1'b1;
				end else begin
					k_inc = !k_last;
					k_clr = k_last;
				end
			end
			ST_FEXW: begin
				if (!sts.exp_busy) begin
					cmd.tot_add = 1'b1;
					k_inc = !k_last;
					k_clr = k_last;
				end
			end
			ST_FLNT: begin
				cmd.ln_start = 1'b1;
				cmd.ln_sel   = LN_TOTAL;
			end
			ST_EMIT:  cmd.emit = sts.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			elem_q  <= '0;
			dims_q  <= DIMS_RST;
			comps_q <= COMPS_RST;
		end else begin
			state_q <= state_d;
			if (k_clr) k_q <= '0;
			else if (k_inc) k_q <= k_q + COMP_W'(1);
			if (elem_clr) elem_q <= '0;
			else if (elem_inc) elem_q <= elem_q + DIM_W'(1);
			if (cfg_valid) begin
				case (cfg_index)
					CFG_DIMS:  dims_q  <= cfg_data[DIMS_W-1:0];
					CFG_COMPS: comps_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	assign cfg_ready = 1'b1;

endmodule

// ----- design/gaussian_mixture_scorer_core.sv -----
// Top level of the diagonal Gaussian mixture log-likelihood scorer.
//
// Scores samples against a mixture of up to 8 diagonal-covariance Gaussians
// over up to 4 dimensions, all values signed Q16.16. An item beat with func
// mean, variance or prior writes one table entry (variances below one LSB
// are stored as one LSB, priors are clipped to 0..1). A sample
// beat brings one dimension value; the dimension is implied by how many
// elements of the current sample have arrived. For each active component the
// block adds -(ln(2*pi*var) + (x-mean)^2/var)/2 to a running sum. After the
// last element it forms ln(prior)+sum per component, takes the maximum M and
// emits M + ln(sum exp(L - M)) as the natural log of the mixture density. If no
// component has a nonzero prior the result is the most negative value with
// saturated set. For each active component a sample element runs the 41-step
// restoring divider for (x-mean)^2/var, and the log of the variance runs
// alongside it. The last element of a sample then adds passes over the
// components for the log priors and for the exponentials, and a final log.
// The finished result sits in an output register, so the next item can start
// while the result beat waits. Configuration: index 0 sets dimensions per
// sample, index 1 sets active components; write only while idle.
module gaussian_mixture_scorer_core import gms_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  item_t                 item,
	output logic                  result_valid,
	input  logic                  result_ready,
	output result_t               result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	// sequencing: element loop over components, then the finishing passes
	gms_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item_func  (item.func),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.sts        (sts),
		.cmd        (cmd)
	);

	// tables, arithmetic units and the result register
	gms_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.sts          (sts),
		.result       (result),
		.result_valid (result_valid),
		.result_ready (result_ready)
	);

endmodule
